FILE: hw/rtl/gss_pkg.sv
// Shared types and constants for the golden-section line search.
// No dependencies; imported by gss_core and golden_section_line_search.
package gss_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int TOL_WIDTH  = 31;
  localparam int FRAC_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = TOL_WIDTH'(66);
  localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = FRAC_WIDTH'(40503);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FRACTION  = CFG_IDX_WIDTH'(1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND,
    PH_NEW_LOW,
    PH_NEW_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_REQ_HIGH,
    ACT_ADV_UP,
    ACT_ADV_DOWN,
    ACT_FINAL
  } act_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } res_ctl_t;

endpackage

FILE: hw/rtl/gss_core.sv
// Search state and combinational step logic of the golden-section line search.
// Depends on gss_pkg.
module gss_core #(
  parameter int COORD_WIDTH = gss_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = gss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic                                opcode,
  input  logic signed [COORD_WIDTH-1:0]       left_bound,
  input  logic signed [COORD_WIDTH-1:0]       right_bound,
  input  logic signed [COORD_WIDTH-1:0]       func_value,
  input  logic [gss_pkg::TOL_WIDTH-1:0]       tolerance,
  input  logic [gss_pkg::FRAC_WIDTH-1:0]      golden_fraction,
  output gss_pkg::res_ctl_t                   res_ctl,
  output logic signed [COORD_WIDTH-1:0]       point,
  output logic signed [COORD_WIDTH-1:0]       min_value,
  output logic [COUNT_WIDTH-1:0]              eval_count,
  output logic signed [COORD_WIDTH-1:0]       final_left,
  output logic signed [COORD_WIDTH-1:0]       final_right
);
  import gss_pkg::*;

  localparam int WW    = COORD_WIDTH + 1;
  localparam int PW    = WW + FRAC_WIDTH + 1;
  localparam int CMP_W = ((WW > TOL_WIDTH) ? WW : TOL_WIDTH) + 1;

  logic signed [COORD_WIDTH-1:0] lo_end, hi_end, inner_low, inner_high;
  logic signed [COORD_WIDTH-1:0] value_low, value_high;
  logic [COUNT_WIDTH-1:0]        evaluations;
  phase_t                        phase;

  logic signed [COORD_WIDTH-1:0] lo_end_next, hi_end_next, inner_low_next, inner_high_next;
  logic signed [COORD_WIDTH-1:0] value_low_next, value_high_next;
  logic [COUNT_WIDTH-1:0]        evaluations_next;
  phase_t                        phase_next;

  act_t                          act;
  logic                          is_value, move_up, done;
  logic signed [COORD_WIDTH-1:0] vl_eff, vh_eff, base_lo, base_hi;
  logic signed [WW-1:0]          width_cur, w_start, w_up, w_down, w_sel, offset;
  logic signed [WW-1:0]          sum_low, sum_high;
  logic signed [COORD_WIDTH-1:0] pt_low_new, pt_high_new;
  logic signed [PW-1:0]          prod;
  logic [COUNT_WIDTH-1:0]        count_bump;

  assign is_value = (opcode == OP_VALUE);
  assign vl_eff   = (phase == PH_NEW_LOW) ? func_value : value_low;
  assign vh_eff   = (phase == PH_SECOND || phase == PH_NEW_HIGH) ? func_value : value_high;
  assign move_up  = (vl_eff > vh_eff);

  assign width_cur = {hi_end[COORD_WIDTH-1], hi_end} - {lo_end[COORD_WIDTH-1], lo_end};
  assign w_start   = {right_bound[COORD_WIDTH-1], right_bound}
                   - {left_bound[COORD_WIDTH-1], left_bound};
  assign w_up      = {hi_end[COORD_WIDTH-1], hi_end} - {inner_low[COORD_WIDTH-1], inner_low};
  assign w_down    = {inner_high[COORD_WIDTH-1], inner_high} - {lo_end[COORD_WIDTH-1], lo_end};
  assign w_sel     = !is_value ? w_start : (move_up ? w_up : w_down);

  assign prod   = PW'(w_sel) * PW'($signed({1'b0, golden_fraction}));
  assign offset = prod[FRAC_WIDTH+WW-1:FRAC_WIDTH];

  assign base_hi     = !is_value ? right_bound : inner_high;
  assign base_lo     = !is_value ? left_bound : inner_low;
  assign sum_low     = {base_hi[COORD_WIDTH-1], base_hi} - offset;
  assign sum_high    = {base_lo[COORD_WIDTH-1], base_lo} + offset;
  assign pt_low_new  = sum_low[COORD_WIDTH-1:0];
  assign pt_high_new = sum_high[COORD_WIDTH-1:0];

  assign done = ($signed({{(CMP_W-WW){width_cur[WW-1]}}, width_cur})
               < $signed({{(CMP_W-TOL_WIDTH){1'b0}}, tolerance}));

  assign count_bump = (evaluations == '1) ? evaluations : evaluations + 1'b1;

  always_comb begin
    act = ACT_NONE;
    if (!is_value) begin
      act = ACT_START;
    end else begin
      unique case (phase) inside
        PH_IDLE:                 act = ACT_NONE;
        PH_FIRST:                act = ACT_REQ_HIGH;
        PH_SECOND:               act = move_up ? ACT_ADV_UP : ACT_ADV_DOWN;
        PH_NEW_LOW, PH_NEW_HIGH: act = done ? ACT_FINAL :
                                       (move_up ? ACT_ADV_UP : ACT_ADV_DOWN);
        default:                 act = ACT_NONE;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    if (go) begin
      unique case (act)
        ACT_START:    phase_next = PH_FIRST;
        ACT_REQ_HIGH: phase_next = PH_SECOND;
        ACT_ADV_UP:   phase_next = PH_NEW_HIGH;
        ACT_ADV_DOWN: phase_next = PH_NEW_LOW;
        ACT_FINAL:    phase_next = PH_IDLE;
        default:      phase_next = phase;
      endcase
    end
  end

  always_comb begin
    lo_end_next      = lo_end;
    hi_end_next      = hi_end;
    inner_low_next   = inner_low;
    inner_high_next  = inner_high;
    value_low_next   = value_low;
    value_high_next  = value_high;
    evaluations_next = evaluations;
    res_ctl.valid    = go && (act != ACT_NONE);
    res_ctl.kind     = KIND_REQUEST;
    point            = '0;
    min_value        = '0;
    final_left       = '0;
    final_right      = '0;
    unique case (act)
      ACT_START: begin
        lo_end_next      = left_bound;
        hi_end_next      = right_bound;
        inner_low_next   = pt_low_new;
        inner_high_next  = pt_high_new;
        value_low_next   = '0;
        value_high_next  = '0;
        evaluations_next = COUNT_WIDTH'(1);
        point            = pt_low_new;
      end
      ACT_REQ_HIGH: begin
        value_low_next   = func_value;
        evaluations_next = count_bump;
        point            = inner_high;
      end
      ACT_ADV_UP: begin
        lo_end_next      = inner_low;
        inner_low_next   = inner_high;
        inner_high_next  = pt_high_new;
        value_low_next   = vh_eff;
        value_high_next  = vh_eff;
        evaluations_next = count_bump;
        point            = pt_high_new;
      end
      ACT_ADV_DOWN: begin
        hi_end_next      = inner_high;
        inner_high_next  = inner_low;
        inner_low_next   = pt_low_new;
        value_low_next   = vl_eff;
        value_high_next  = vl_eff;
        evaluations_next = count_bump;
        point            = pt_low_new;
      end
      ACT_FINAL: begin
        value_low_next  = vl_eff;
        value_high_next = vh_eff;
        res_ctl.kind    = KIND_FINAL;
        point           = (vl_eff < vh_eff) ? lo_end : hi_end;
        min_value       = (vl_eff < vh_eff) ? vl_eff : vh_eff;
        final_left      = lo_end;
        final_right     = hi_end;
      end
      default: begin
        res_ctl.valid = 1'b0;
      end
    endcase
    eval_count = evaluations_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      evaluations <= '0;
    end else begin
      phase <= phase_next;
      if (go) begin
        evaluations <= evaluations_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      lo_end     <= lo_end_next;
      hi_end     <= hi_end_next;
      inner_low  <= inner_low_next;
      inner_high <= inner_high_next;
      value_low  <= value_low_next;
      value_high <= value_high_next;
    end
  end

  a_final_goes_idle: assert property (@(posedge clk) disable iff (rst)
    go && res_ctl.valid && res_ctl.kind == KIND_FINAL |=> phase == PH_IDLE)
    else $error("final answer did not end the search");

  a_busy_has_count: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> evaluations != '0)
    else $error("active search with zero evaluations");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_NEW_HIGH)
    else $error("search phase out of range");

endmodule

FILE: hw/rtl/golden_section_line_search.sv
// Top level of the golden-section line search: channels, config registers,
// input stage and result register. Depends on gss_pkg and gss_core.
//
//  channel | signals                                         | direction
//  in      | in_valid in_ready opcode left_bound right_bound |
//          | func_value                                      | to block
//  out     | out_valid out_ready kind point min_value        |
//          | eval_count final_left final_right               | from block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | to block
//
// One item per cycle while out is not stalled; an in item goes to the input register
// and its result to the result register (the step logic runs between them).
// cfg_ready is always high; a write lands at the next edge.
// Synchronous reset clears the valid flags and search phase and resets the config.
// An out stall holds the result register and, one item later, the input stage.
module golden_section_line_search #(
  parameter int COORD_WIDTH = gss_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = gss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic signed [COORD_WIDTH-1:0]        left_bound,
  input  logic signed [COORD_WIDTH-1:0]        right_bound,
  input  logic signed [COORD_WIDTH-1:0]        func_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 kind,
  output logic signed [COORD_WIDTH-1:0]        point,
  output logic signed [COORD_WIDTH-1:0]        min_value,
  output logic [COUNT_WIDTH-1:0]               eval_count,
  output logic signed [COORD_WIDTH-1:0]        final_left,
  output logic signed [COORD_WIDTH-1:0]        final_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gss_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [gss_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import gss_pkg::*;

  logic [TOL_WIDTH-1:0]  tolerance;
  logic [FRAC_WIDTH-1:0] golden_fraction;

  logic                          s_valid;
  logic                          s_opcode;
  logic signed [COORD_WIDTH-1:0] s_left, s_right, s_value;

  logic                          stage_go, go;
  res_ctl_t                      res_ctl;
  logic signed [COORD_WIDTH-1:0] r_point, r_min, r_left, r_right;
  logic [COUNT_WIDTH-1:0]        r_count;

  assign cfg_ready = 1'b1;
  assign stage_go  = !out_valid || out_ready;
  assign go        = s_valid && stage_go;
  assign in_ready  = !s_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= TOL_RESET;
      golden_fraction <= FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tolerance       <= cfg_data[TOL_WIDTH-1:0];
        CFG_FRACTION:  golden_fraction <= cfg_data[FRAC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_opcode <= opcode;
      s_left   <= left_bound;
      s_right  <= right_bound;
      s_value  <= func_value;
    end
  end

  gss_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .opcode          (s_opcode),
    .left_bound      (s_left),
    .right_bound     (s_right),
    .func_value      (s_value),
    .tolerance       (tolerance),
    .golden_fraction (golden_fraction),
    .res_ctl         (res_ctl),
    .point           (r_point),
    .min_value       (r_min),
    .eval_count      (r_count),
    .final_left      (r_left),
    .final_right     (r_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go) begin
      out_valid <= res_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res_ctl.valid) begin
      kind        <= res_ctl.kind;
      point       <= r_point;
      min_value   <= r_min;
      eval_count  <= r_count;
      final_left  <= r_left;
      final_right <= r_right;
    end
  end

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s_valid))
    else $error("result appeared without an item in the input stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s_valid && out_valid && !out_ready)
    else $error("input held off without a full pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(point))
    else $error("stalled result changed before transfer");

endmodule

FILE: dv/tb_golden_section_line_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for golden_section_line_search: a queued driver, a random-stall
// monitor and a bit-true search predictor. Depends on gss_pkg and the block's RTL.
module tb_golden_section_line_search;
  import gss_pkg::*;

  localparam int CW = 32;
  localparam int NW = 8;
  localparam int EVAL_MAX = (1 << NW) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int SEARCH_CAP = 270;
  localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

  typedef enum int {CURVE_BOWL, CURVE_NOISE, CURVE_FLAT} curve_t;

  typedef struct packed {
    logic op;
    logic [CW-1:0] left;
    logic [CW-1:0] right;
    logic [CW-1:0] fval;
  } search_cmd_t;

  typedef struct packed {
    logic kind;
    logic [CW-1:0] point;
    logic [CW-1:0] min_value;
    logic [NW-1:0] evals;
    logic [CW-1:0] left;
    logic [CW-1:0] right;
  } search_reply_t;

  typedef struct {
    logic signed [63:0] lo, hi, in_lo, in_hi, f_lo, f_hi;
    int unsigned evals;
    phase_t ph;
    logic [TOL_WIDTH-1:0] tol;
    logic [FRAC_WIDTH-1:0] frac;
  } search_state_t;

  logic clk, rst;
  logic in_valid, in_ready, opcode;
  logic signed [CW-1:0] left_bound, right_bound, func_value;
  logic out_valid, out_ready, kind;
  logic signed [CW-1:0] point, min_value, final_left, final_right;
  logic [NW-1:0] eval_count;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  search_cmd_t cmd_queue[$];
  search_reply_t reply_queue[$];
  search_state_t plan, model;
  search_reply_t plan_reply;
  curve_t curve;
  logic signed [63:0] target;
  logic signed [CW-1:0] flat_level;
  bit steady;
  int errors;
  int quiet_cycles;

  golden_section_line_search #(.COORD_WIDTH(CW), .COUNT_WIDTH(NW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .left_bound(left_bound), .right_bound(right_bound), .func_value(func_value),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .point(point),
    .min_value(min_value), .eval_count(eval_count),
    .final_left(final_left), .final_right(final_right),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic search_state_t fresh_state();
    search_state_t s;
    s.lo = 0; s.hi = 0; s.in_lo = 0; s.in_hi = 0; s.f_lo = 0; s.f_hi = 0;
    s.evals = 0;
    s.ph = PH_IDLE;
    s.tol = TOL_RESET;
    s.frac = FRAC_RESET;
    return s;
  endfunction

  function automatic logic signed [63:0] golden_offset(input logic signed [63:0] w,
                                                       input logic [FRAC_WIDTH-1:0] g);
    logic signed [63:0] p;
    p = w * $signed({48'd0, g});
    return p >>> 16;
  endfunction

  function automatic void issue_probe(inout search_state_t s, input logic signed [63:0] at,
                                      output search_reply_t r);
    if (s.evals < EVAL_MAX) s.evals++;
    r = '0;
    r.kind = KIND_REQUEST;
    r.point = at[CW-1:0];
    r.evals = s.evals[NW-1:0];
  endfunction

  // keep the side that holds the smaller value, probe one new point
  function automatic void narrow(inout search_state_t s, output search_reply_t r);
    if (s.f_lo > s.f_hi) begin
      s.lo = s.in_lo;
      s.in_lo = s.in_hi;
      s.f_lo = s.f_hi;
      s.in_hi = s.lo + golden_offset(s.hi - s.lo, s.frac);
      s.ph = PH_NEW_HIGH;
      issue_probe(s, s.in_hi, r);
    end else begin
      s.hi = s.in_hi;
      s.in_hi = s.in_lo;
      s.f_hi = s.f_lo;
      s.in_lo = s.hi - golden_offset(s.hi - s.lo, s.frac);
      s.ph = PH_NEW_LOW;
      issue_probe(s, s.in_lo, r);
    end
  endfunction

  function automatic bit search_step(inout search_state_t s, input search_cmd_t c,
                                     output search_reply_t r);
    logic signed [63:0] f;
    r = '0;
    f = $signed(c.fval);
    if (c.op == OP_START) begin
      s.lo = $signed(c.left);
      s.hi = $signed(c.right);
      s.in_lo = s.hi - golden_offset(s.hi - s.lo, s.frac);
      s.in_hi = s.lo + golden_offset(s.hi - s.lo, s.frac);
      s.f_lo = 0;
      s.f_hi = 0;
      s.evals = 0;
      s.ph = PH_FIRST;
      issue_probe(s, s.in_lo, r);
      return 1'b1;
    end
    case (s.ph)
      PH_FIRST: begin
        s.f_lo = f;
        s.ph = PH_SECOND;
        issue_probe(s, s.in_hi, r);
        return 1'b1;
      end
      PH_SECOND: begin
        s.f_hi = f;
        narrow(s, r);
        return 1'b1;
      end
      PH_NEW_LOW, PH_NEW_HIGH: begin
        if (s.ph == PH_NEW_LOW) s.f_lo = f;
        else s.f_hi = f;
        if (s.hi - s.lo >= $signed({33'd0, s.tol})) begin
          narrow(s, r);
          return 1'b1;
        end
        s.ph = PH_IDLE;
        r.kind = KIND_FINAL;
        r.evals = s.evals[NW-1:0];
        r.left = s.lo[CW-1:0];
        r.right = s.hi[CW-1:0];
        if (s.f_lo < s.f_hi) begin
          r.point = s.lo[CW-1:0];
          r.min_value = s.f_lo[CW-1:0];
        end else begin
          r.point = s.hi[CW-1:0];
          r.min_value = s.f_hi[CW-1:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [63:0] any_coord();
    return $signed(CW'($urandom));
  endfunction

  function automatic logic signed [CW-1:0] curve_value(input logic signed [63:0] x);
    logic signed [63:0] d;
    case (curve)
      CURVE_BOWL: begin
        d = x - target;
        if (d < 0) d = -d;
        if (d > COORD_MAX) d = COORD_MAX;
        return d[CW-1:0];
      end
      CURVE_FLAT: return flat_level;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(input logic op, input logic signed [63:0] l, r, f);
    search_cmd_t c;
    c.op = op;
    c.left = l[CW-1:0];
    c.right = r[CW-1:0];
    c.fval = f[CW-1:0];
    void'(search_step(plan, c, plan_reply));
    cmd_queue.push_back(c);
  endtask

  task automatic push_value();
    push_cmd(OP_VALUE, any_coord(), any_coord(), curve_value($signed(plan_reply.point)));
  endtask

  // mostly complete searches, some dropped early by a fresh start
  task automatic run_searches(input int n_cmds, input int span_log);
    int issued, limit, taken, pick;
    logic signed [63:0] lo, hi;
    issued = 0;
    while (issued < n_cmds) begin
      lo = any_coord();
      pick = $urandom_range(99);
      if (pick < 10) hi = any_coord();
      else if (pick < 15) hi = lo;
      else if (pick < 22) hi = lo - $urandom_range(1, 1 << span_log);
      else hi = lo + $urandom_range(1, 1 << span_log);
      if (hi > COORD_MAX) hi = COORD_MAX;
      if (hi < COORD_MIN) hi = COORD_MIN;
      curve = curve_t'($urandom_range(2));
      if ($urandom_range(1) == 0) target = any_coord();
      else target = lo + $urandom_range(1 << span_log);
      flat_level = $urandom;
      limit = ($urandom_range(99) < 15) ? $urandom_range(8) : SEARCH_CAP;
      push_cmd(OP_START, lo, hi, any_coord());
      taken = 0;
      while (plan.ph != PH_IDLE && taken < limit) begin
        push_value();
        taken++;
      end
      issued += taken + 1;
      if (plan.ph == PH_IDLE && $urandom_range(99) < 10) push_value();
    end
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || reply_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [TOL_WIDTH-1:0] tol, input logic [FRAC_WIDTH-1:0] frac);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= {1'($urandom), tol};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FRACTION;
    cfg_data <= {16'($urandom), frac};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    plan.tol = tol;
    plan.frac = frac;
    model.tol = tol;
    model.frac = frac;
  endtask

  task automatic compare_field(input string what, input logic [CW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // driver: predict on each input transfer, then present the next command
  always @(posedge clk) begin
    search_cmd_t c;
    search_reply_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.op = opcode;
        c.left = left_bound;
        c.right = right_bound;
        c.fval = func_value;
        if (search_step(model, c, r)) reply_queue.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
          c = cmd_queue.pop_front();
          in_valid <= 1'b1;
          opcode <= c.op;
          left_bound <= c.left;
          right_bound <= c.right;
          func_value <= c.fval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, check each output transfer in order
  always @(posedge clk) begin
    search_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 37;
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected reply kind %0d point %h", $time, kind, point);
          errors++;
        end else begin
          want = reply_queue.pop_front();
          compare_field("kind", CW'(want.kind), CW'(kind));
          compare_field("point", want.point, point);
          compare_field("min_value", want.min_value, min_value);
          compare_field("eval_count", CW'(want.evals), CW'(eval_count));
          compare_field("final_left", want.left, final_left);
          compare_field("final_right", want.right, final_right);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("golden_section_line_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_START;
    left_bound = '0;
    right_bound = '0;
    func_value = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOLERANCE;
    cfg_data = '0;
    steady = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    plan = fresh_state();
    model = fresh_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // value with no search running: dropped
    push_cmd(OP_VALUE, 0, 0, COORD_MIN);
    // full-range interval, then abandoned by a new start
    push_cmd(OP_START, COORD_MIN, COORD_MAX, 0);
    push_cmd(OP_VALUE, 0, 0, COORD_MAX);
    push_cmd(OP_VALUE, 0, 0, COORD_MIN);
    push_cmd(OP_VALUE, 0, 0, 0);
    // reversed interval, equal values
    push_cmd(OP_START, COORD_MAX, COORD_MIN, -1);
    repeat (3) push_cmd(OP_VALUE, -1, -1, 5);
    // zero-width interval
    push_cmd(OP_START, 64'sh10000, 64'sh10000, 0);
    push_cmd(OP_VALUE, 0, 0, -1);
    push_cmd(OP_VALUE, 0, 0, -2);
    push_cmd(OP_VALUE, 0, 0, -3);
    push_cmd(OP_VALUE, -1, -1, COORD_MAX);

    run_searches(100, 16);
    drain();
    set_config(TOL_WIDTH'(1), 16'hFFFF);
    run_searches(100, 9);
    drain();
    set_config(31'h7FFF_FFFF, 16'h8000);
    steady <= 1'b1;
    run_searches(100, 30);
    drain();
    steady <= 1'b0;
    set_config(TOL_WIDTH'(1), 16'h8000);
    run_searches(100, 20);
    repeat (2) begin
      drain();
      set_config(TOL_WIDTH'($urandom_range(1 << 20, 1)), FRAC_WIDTH'($urandom_range(65535, 32768)));
      run_searches(100, 24);
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && reply_queue.size() == 0) begin
      $display("golden_section_line_search verification clean");
    end else begin
      $display("golden_section_line_search verification failed");
    end
    $finish;
  end

endmodule

FILE: golden_section_line_search.f
hw/rtl/gss_pkg.sv
hw/rtl/gss_core.sv
hw/rtl/golden_section_line_search.sv
dv/tb_golden_section_line_search.sv
